// ===== design/sgf_pkg.sv =====
// ----------------------------------------------------------------------------
// Scharr gradient filter package
// Shared types, kernel weights, register indexes and output queue sizing.
// ----------------------------------------------------------------------------
package sgf_pkg;

    localparam int PIX_W      = 8;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 1;

    typedef logic [PIX_W-1:0]      t_pix;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;

    // Register indexes on the configuration port.
    localparam t_cfg_idx CFG_LINE_WIDTH = 1'd0;
    localparam t_cfg_idx CFG_X_DERIV    = 1'd1;

    // Register reset values.
    localparam t_cfg_data LINE_WIDTH_RST = 12'd640;
    localparam logic      X_DERIV_RST    = 1'b1;

    // Smallest usable line width.
    localparam int MIN_LINE_WIDTH = 3;

    // Scharr weights and pixel ceiling.
    localparam int K_SIDE  = 3;
    localparam int K_MID   = 10;
    localparam int PIX_MAX = 255;

    // Output queue: holds finished words while the sink stalls.
    localparam int OQ_DEPTH = 8;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);

    // One result word.
    typedef struct packed {
        t_pix pixel;
        logic line_end;
    } t_res;

endpackage

// ===== design/sgf_pix_in_if.sv =====
// ----------------------------------------------------------------------------
// Input pixel channel
// Valid/ready channel that carries one raster-order pixel per word.
// ----------------------------------------------------------------------------
interface sgf_pix_in_if;
    logic          valid;
    logic          ready;
    sgf_pkg::t_pix pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

// ===== design/sgf_pix_out_if.sv =====
// ----------------------------------------------------------------------------
// Output pixel channel
// Valid/ready channel that carries one gradient pixel and a line end flag.
// ----------------------------------------------------------------------------
interface sgf_pix_out_if;
    logic          valid;
    logic          ready;
    sgf_pkg::t_pix pixel_out;
    logic          line_end;

    modport source (output valid, output pixel_out, output line_end, input ready);
    modport sink   (input valid, input pixel_out, input line_end, output ready);
endinterface

// ===== design/scharr_gradient_3x3_filter.sv =====
// ----------------------------------------------------------------------------
// Scharr 3x3 gradient filter
// Raster pixel stream in, clamped X or Y Scharr gradient stream out.
// ----------------------------------------------------------------------------
//
// Channel     Dir  Signals                              Word accepted when
// i_pix       in   valid, ready, pixel_in               valid && ready
// o_pix       out  valid, ready, pixel_out, line_end    valid && ready
// cfg         in   i_cfg_we, i_cfg_idx, i_cfg_data      i_cfg_we
//
// One pixel is accepted every clock while i_pix.ready is high. The two previous
// rows live in a single line memory, 16 bits wide, one entry per column: the
// accept cycle reads it, and the next cycle computes the kernel and writes the
// entry back. A result enters the output queue in the cycle after its pixel is
// accepted and can leave at the following edge. The last pixel of each line
// after the first yields two words; the eight-entry output queue absorbs them,
// and column 0 yields none, so one pixel per clock is sustained unless the sink
// stalls. Reset is synchronous and clears the counters, the window and the
// queue; the line memory needs no clearing pass. i_pix.ready drops only when
// the queue could not take the words of the pixel in flight plus a new one.

module scharr_gradient_3x3_filter #(
    parameter int MAX_LINE_WIDTH = 2048
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  sgf_pkg::t_cfg_idx     i_cfg_idx,
    input  sgf_pkg::t_cfg_data    i_cfg_data,
    sgf_pix_in_if.sink            i_pix,
    sgf_pix_out_if.source         o_pix
);

    // Column index width, and a compare width that holds both the register
    // value and the maximum line width.
    localparam int AW = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
    localparam int WW = ($clog2(MAX_LINE_WIDTH + 1) > sgf_pkg::CFG_DATA_W) ?
                        $clog2(MAX_LINE_WIDTH + 1) : sgf_pkg::CFG_DATA_W;
    localparam int TW = 14;  // signed kernel sum, |sum| <= 16 * 255

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    sgf_pkg::t_cfg_data r_line_width;
    logic               r_x_deriv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= sgf_pkg::LINE_WIDTH_RST;
            r_x_deriv    <= sgf_pkg::X_DERIV_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sgf_pkg::CFG_LINE_WIDTH: r_line_width <= i_cfg_data;
                sgf_pkg::CFG_X_DERIV:    r_x_deriv    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Effective width: the register clamped to the supported range.
    logic [WW-1:0] w_lw;
    logic [WW-1:0] w_eff;

    always_comb begin
        w_lw = WW'(r_line_width);
        if (w_lw < WW'(sgf_pkg::MIN_LINE_WIDTH)) begin
            w_eff = WW'(sgf_pkg::MIN_LINE_WIDTH);
        end else if (w_lw > WW'(MAX_LINE_WIDTH)) begin
            w_eff = WW'(MAX_LINE_WIDTH);
        end else begin
            w_eff = w_lw;
        end
    end

    // ------------------------------------------------------------------
    // Output queue state (declared early: it sets input ready)
    // ------------------------------------------------------------------
    sgf_pkg::t_res               r_oq [sgf_pkg::OQ_DEPTH];
    logic [sgf_pkg::OQ_AW-1:0]   r_oq_wr;
    logic [sgf_pkg::OQ_AW-1:0]   r_oq_rd;
    logic [sgf_pkg::OQ_AW:0]     r_oq_cnt;

    // Stage 1 registers: the pixel whose line memory read is in progress.
    logic          r_s1_vld;
    sgf_pkg::t_pix r_s1_pix;
    logic [AW-1:0] r_s1_idx;
    logic [1:0]    r_s1_n;       // words this pixel will push
    logic          r_s1_zero;    // first word is a border zero
    logic          r_s1_calc;    // first word carries the kernel result

    // Accept a pixel only if the queue can take both the words of the pixel
    // in stage 1 and up to two words of the new one.
    logic w_in_acc;

    assign i_pix.ready = ((sgf_pkg::OQ_AW+1)'(r_oq_cnt) + (sgf_pkg::OQ_AW+1)'(r_s1_n))
                         <= (sgf_pkg::OQ_AW+1)'(sgf_pkg::OQ_DEPTH - 2);
    assign w_in_acc    = i_pix.valid && i_pix.ready;

    // ------------------------------------------------------------------
    // Column and line counters, advanced at accept
    // ------------------------------------------------------------------
    logic [AW-1:0] r_col;
    logic [1:0]    r_line_cnt;   // saturates at two
    logic          w_last;
    logic          w_has1;

    assign w_last = WW'(r_col) >= (w_eff - WW'(1));
    assign w_has1 = (r_line_cnt != 2'd0) && (r_col != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_line_cnt <= 2'd0;
        end else if (w_in_acc) begin
            if (w_last) begin
                r_col <= '0;
                if (r_line_cnt != 2'd2) begin
                    r_line_cnt <= r_line_cnt + 2'd1;
                end
            end else begin
                r_col <= r_col + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s1_n   <= 2'd0;
        end else begin
            r_s1_vld <= w_in_acc;
            if (w_in_acc) begin
                r_s1_n <= w_has1 ? (w_last ? 2'd2 : 2'd1) : 2'd0;
            end else begin
                r_s1_n <= 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_pix  <= i_pix.pixel_in;
            r_s1_idx  <= r_col;
            r_s1_zero <= (r_col == AW'(1));
            r_s1_calc <= (r_line_cnt == 2'd2) && (r_col > AW'(1));
        end
    end

    // ------------------------------------------------------------------
    // Line memory: {older row, newer row} per column, registered read.
    // Reads and writes in the same cycle always hit different columns,
    // since consecutive pixels never share a column.
    // ------------------------------------------------------------------
    logic [2*sgf_pkg::PIX_W-1:0] r_line_mem [MAX_LINE_WIDTH];
    logic [2*sgf_pkg::PIX_W-1:0] r_mem_q;
    logic [2*sgf_pkg::PIX_W-1:0] w_mem_wdata;

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mem_q <= r_line_mem[r_col];
        end
        if (r_s1_vld) begin
            r_line_mem[r_s1_idx] <= w_mem_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: window, kernel, clamp
    // ------------------------------------------------------------------
    // Window columns: index 0..2 hold column c-2 of the older, newer and
    // current rows; index 3..5 hold column c-1 of the same rows.
    sgf_pkg::t_pix r_win [6];

    sgf_pkg::t_pix     w_a2, w_b2, w_c2;
    logic signed [9:0] w_da, w_db, w_dc;
    logic signed [TW-1:0] w_t;
    sgf_pkg::t_pix     w_clamp;
    sgf_pkg::t_pix     w_value;

    assign w_a2        = r_mem_q[2*sgf_pkg::PIX_W-1:sgf_pkg::PIX_W];
    assign w_b2        = r_mem_q[sgf_pkg::PIX_W-1:0];
    assign w_c2        = r_s1_pix;
    assign w_mem_wdata = {w_b2, w_c2};

    always_comb begin
        if (r_x_deriv) begin
            // Difference across columns, weighted down the rows.
            w_da = $signed({2'b00, w_a2})     - $signed({2'b00, r_win[0]});
            w_db = $signed({2'b00, w_b2})     - $signed({2'b00, r_win[1]});
            w_dc = $signed({2'b00, w_c2})     - $signed({2'b00, r_win[2]});
        end else begin
            // Difference down the rows, weighted across columns.
            w_da = $signed({2'b00, r_win[2]}) - $signed({2'b00, r_win[0]});
            w_db = $signed({2'b00, r_win[5]}) - $signed({2'b00, r_win[3]});
            w_dc = $signed({2'b00, w_c2})     - $signed({2'b00, w_a2});
        end
        w_t = TW'(sgf_pkg::K_SIDE * w_da + sgf_pkg::K_MID * w_db
                  + sgf_pkg::K_SIDE * w_dc);
        if (w_t < $signed(TW'(0))) begin
            w_clamp = '0;
        end else if (w_t > $signed(TW'(sgf_pkg::PIX_MAX))) begin
            w_clamp = sgf_pkg::t_pix'(sgf_pkg::PIX_MAX);
        end else begin
            w_clamp = w_t[sgf_pkg::PIX_W-1:0];
        end
        w_value = (r_s1_calc && !r_s1_zero) ? w_clamp : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (r_s1_vld) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= w_a2;
            r_win[4] <= w_b2;
            r_win[5] <= w_c2;
        end
    end

    // ------------------------------------------------------------------
    // Output queue: up to two pushes per cycle, one pop
    // ------------------------------------------------------------------
    logic w_pop;

    assign w_pop           = o_pix.valid && o_pix.ready;
    assign o_pix.valid     = (r_oq_cnt != '0);
    assign o_pix.pixel_out = r_oq[r_oq_rd].pixel;
    assign o_pix.line_end  = r_oq[r_oq_rd].line_end;

    always_ff @(posedge i_clk) begin
        if (r_s1_n != 2'd0) begin
            r_oq[r_oq_wr] <= '{pixel: w_value, line_end: 1'b0};
        end
        if (r_s1_n == 2'd2) begin
            // Last column of the line: always zero, flagged as line end.
            r_oq[r_oq_wr + sgf_pkg::OQ_AW'(1)] <= '{pixel: '0, line_end: 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wr  <= '0;
            r_oq_rd  <= '0;
            r_oq_cnt <= '0;
        end else begin
            r_oq_wr  <= r_oq_wr + sgf_pkg::OQ_AW'(r_s1_n);
            if (w_pop) begin
                r_oq_rd <= r_oq_rd + sgf_pkg::OQ_AW'(1);
            end
            r_oq_cnt <= r_oq_cnt + (sgf_pkg::OQ_AW+1)'(r_s1_n)
                        - (sgf_pkg::OQ_AW+1)'(w_pop);
        end
    end

endmodule

// ===== design/sgf_checker.sv =====
// ----------------------------------------------------------------------------
// Scharr gradient filter port checker
// Watches the output port and checks stall hold, border and reset rules.
// ----------------------------------------------------------------------------
module sgf_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input sgf_pkg::t_pix i_out_pixel,
    input logic          i_out_line_end
);

    logic w_out_acc;
    logic r_line_start;

    assign w_out_acc = i_out_valid && i_out_ready;

    // Set when the next delivered word opens a new output line.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_start <= 1'b1;
        end else if (w_out_acc) begin
            r_line_start <= i_out_line_end;
        end
    end

    // A stalled word stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_pixel) && $stable(i_out_line_end))
        else $error("output word changed while stalled");

    // The last column of a line is a border and is always zero.
    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_line_end |-> i_out_pixel == '0)
        else $error("line end word is not zero");

    // The first column of a line is a border and is always zero.
    a_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc && r_line_start |-> i_out_pixel == '0)
        else $error("first word of a line is not zero");

    // Reset empties the output queue.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind scharr_gradient_3x3_filter sgf_checker u_sgf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_pix.valid),
    .i_out_ready    (o_pix.ready),
    .i_out_pixel    (o_pix.pixel_out),
    .i_out_line_end (o_pix.line_end)
);
